// ===== rtl/core/lsf_pkg.sv =====
// Package for the line substring filter: sizes, register indexes, the
// configuration struct and the effective pattern length function.
// Depends on nothing; every other file imports it.
package lsf_pkg;

   localparam int MAX_PATTERN    = 32;
   localparam int LINE_LIMIT     = 256;
   localparam int LEN_W          = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W          = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CMP_W          = LEN_W + 1;
   localparam int PLEN_W         = 6;
   localparam int LENGTH_W       = 9;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int WORD_BYTES     = 8;
   localparam int PATTERN_STORED = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES3 = 3'd4;

   typedef logic [MAX_PATTERN-1:0][7:0] pattern_type;

   typedef struct packed {
      pattern_type            pattern;
      logic [LEN_W-1:0]       eff_len;
   } cfg_type;

   function automatic logic [LEN_W-1:0] eff_length(input pattern_type pattern,
                                                   input logic [PLEN_W-1:0] plen);
      logic [LEN_W-1:0] n;
      logic [LEN_W-1:0] e;
      if (int'(plen) > MAX_PATTERN) begin
         n = LEN_W'(MAX_PATTERN);
      end else begin
         n = LEN_W'(plen);
      end
      e = n;
      for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
         if (i < int'(n) && pattern[i] == 8'h00) begin
            e = LEN_W'(i);
         end
      end
      return e;
   endfunction

endpackage

// ===== rtl/core/lsf_intf.sv =====
// Channel interfaces of the line substring filter: text beats, result beats
// and configuration writes. Depends on lsf_pkg for the field widths.
interface lsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       line_end;
   modport source (output valid, text_byte, line_end, input ready);
   modport sink   (input valid, text_byte, line_end, output ready);
endinterface

interface lsf_rsp_if;
   import lsf_pkg::*;
   logic                valid;
   logic                ready;
   logic                line_matched;
   logic [LENGTH_W-1:0] line_length;
   modport source (output valid, line_matched, line_length, input ready);
   modport sink   (input valid, line_matched, line_length, output ready);
endinterface

interface lsf_csr_if;
   import lsf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lsf_csr.sv =====
// Configuration registers of the line substring filter and the registered
// effective pattern length. Depends on lsf_pkg and lsf_intf.
module lsf_csr import lsf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   lsf_csr_if.sink       csr,
   output cfg_type       cfg
);

   logic [PLEN_W-1:0] plen_ff, plen_in;
   pattern_type       pattern_ff, pattern_in;
   logic [LEN_W-1:0]  eff_len_ff, eff_len_in;
   logic [1:0]        word_sel;
   logic              word_wr;
   logic              wr;

   assign csr.ready = 1'b1;
   assign wr        = csr.valid && csr.ready;

   always_comb begin
      word_wr  = 1'b0;
      word_sel = 2'd0;
      case (csr.index)
         REG_PATTERN_BYTES0: begin word_wr = 1'b1; word_sel = 2'd0; end
         REG_PATTERN_BYTES1: begin word_wr = 1'b1; word_sel = 2'd1; end
         REG_PATTERN_BYTES2: begin word_wr = 1'b1; word_sel = 2'd2; end
         REG_PATTERN_BYTES3: begin word_wr = 1'b1; word_sel = 2'd3; end
         default: begin word_wr = 1'b0; word_sel = 2'd0; end
      endcase
   end

   always_comb begin
      plen_in    = plen_ff;
      pattern_in = pattern_ff;
      if (wr && csr.index == REG_PATTERN_LENGTH) begin
         plen_in = csr.data[PLEN_W-1:0];
      end
      if (wr && word_wr) begin
         for (int p = 0; p < MAX_PATTERN; p++) begin
            if (p < PATTERN_STORED && (p / WORD_BYTES) == int'(word_sel)) begin
               pattern_in[p] = csr.data[(p % WORD_BYTES) * 8 +: 8];
            end
         end
      end
      eff_len_in = eff_length(pattern_in, plen_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff    <= '0;
         pattern_ff <= '0;
         eff_len_ff <= '0;
      end else begin
         plen_ff    <= plen_in;
         pattern_ff <= pattern_in;
         eff_len_ff <= eff_len_in;
      end
   end

   assign cfg.pattern = pattern_ff;
   assign cfg.eff_len = eff_len_ff;

endmodule

// ===== rtl/core/lsf_cell.sv =====
// One window cell: holds one recent text byte, passes it on to the next older
// cell and compares the byte it takes in with its aligned pattern byte.
// Depends on lsf_pkg.
module lsf_cell import lsf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_index,
   input  cfg_type          cfg,
   input  logic             shift_en,
   input  logic             clear,
   input  logic [7:0]       byte_in,
   output logic [7:0]       byte_out,
   output logic             hit
);

   logic [7:0]       byte_ff, byte_in_next;
   logic [CMP_W-1:0] pos;
   logic             in_window;

   assign in_window = CMP_W'(cell_index) < CMP_W'(cfg.eff_len);
   assign pos       = CMP_W'(cfg.eff_len) - CMP_W'(1) - CMP_W'(cell_index);
   assign hit       = !in_window || (byte_in == cfg.pattern[pos[IDX_W-1:0]]);

   always_comb begin
      byte_in_next = byte_ff;
      if (clear) begin
         byte_in_next = 8'h00;
      end else if (shift_en) begin
         byte_in_next = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in_next;
      end
   end

   assign byte_out = byte_ff;

endmodule

// ===== rtl/core/line_substring_filter.sv =====
// Line substring filter: text beats in, one result beat per line end.
// Output: the result of a line end beat is registered and offered in the cycle after it is taken.
// Throughput: one text beat per cycle, set by the shift and compare of the window cell
// chain; a waiting result stalls only further beats.
// Reset: synchronous; clears the window, counters, the result valid flag and all
// configuration registers.
module line_substring_filter import lsf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lsf_req_if.sink  req,
   lsf_rsp_if.source rsp,
   lsf_csr_if.sink  csr
);

   cfg_type               cfg;
   logic [MAX_PATTERN-1:0][7:0] window;
   logic [MAX_PATTERN-1:0] hits;
   logic                  accept, take_byte, searching, line_done;
   logic [LENGTH_W-1:0]   count_ff, count_in;
   logic                  nul_ff, nul_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  matched_ff, matched_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;

   lsf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign line_done = accept && req.line_end;
   assign take_byte = accept && !req.line_end && int'(count_ff) < LINE_LIMIT;
   assign searching = take_byte && req.text_byte != 8'h00 && !nul_ff;

   for (genvar m = 0; m < MAX_PATTERN; m++) begin : g_cell
      logic [7:0] cell_byte_in;
      if (m == 0) begin : g_head
         assign cell_byte_in = req.text_byte;
      end else begin : g_body
         assign cell_byte_in = window[m-1];
      end
      lsf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(m)),
         .cfg        (cfg),
         .shift_en   (searching),
         .clear      (line_done),
         .byte_in    (cell_byte_in),
         .byte_out   (window[m]),
         .hit        (hits[m])
      );
   end

   always_comb begin
      count_in     = count_ff;
      nul_in       = nul_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      matched_in   = matched_ff;
      length_in    = length_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (line_done) begin
         count_in     = '0;
         nul_in       = 1'b0;
         found_in     = 1'b0;
         rsp_valid_in = 1'b1;
         matched_in   = found_ff || cfg.eff_len == '0;
         length_in    = count_ff;
      end else if (take_byte) begin
         count_in = count_ff + LENGTH_W'(1);
         if (req.text_byte == 8'h00) begin
            nul_in = 1'b1;
         end
         if (searching && cfg.eff_len != '0 && (&hits)) begin
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         nul_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         nul_ff       <= nul_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
      length_ff  <= length_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.line_matched = matched_ff;
   assign rsp.line_length  = length_ff;

endmodule

// ===== rtl/core/lsf_checker.sv =====
// Port-level checks for the line substring filter, and the bind that
// attaches them to the top level. Depends on lsf_pkg.
module lsf_checker import lsf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_line_end,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_line_matched,
   input logic [LENGTH_W-1:0] rsp_line_length
);

   a_line_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_line_end |=> rsp_valid)
      else $error("A line end beat was taken but no result followed.");

   a_result_from_line_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_line_end))
      else $error("A result appeared without a line end beat.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Text beats were refused with no result waiting.");

   a_length_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_line_length) <= LINE_LIMIT)
      else $error("The line length exceeds the line limit.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_matched)
                                  && $stable(rsp_line_length))
      else $error("A stalled result beat changed.");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_line_end     (req.line_end),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_line_matched (rsp.line_matched),
   .rsp_line_length  (rsp.line_length)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for line_substring_filter: a directed table, then random text
// lines, each line end checked against a per-line search predictor in this file or, for
// typed rows, the table. Depends on lsf_pkg and the channel interfaces in rtl/core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lsf_pkg::*;

   typedef enum logic [1:0] {ROW_CHAR, ROW_END, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   data;
      logic [7:0]              ch;
      bit                      typed;
      bit                      matched;
      logic [LENGTH_W-1:0]     length;
   } stim_row_type;

   typedef struct {
      bit                      matched;
      logic [LENGTH_W-1:0]     length;
   } line_result_type;

   localparam logic [CSR_INDEX_W-1:0] REG_BEYOND_LIST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_LAST_INDEX  = 3'd7;
   localparam logic [7:0] CHR_NUL = 8'h00;
   localparam logic [7:0] CHR_A   = 8'h61;
   localparam logic [7:0] CHR_B   = 8'h62;
   localparam logic [7:0] CHR_C   = 8'h63;
   localparam logic [7:0] CHR_X   = 8'h78;
   localparam logic [7:0] CHR_Z   = 8'h7a;
   localparam logic [CSR_DATA_W-1:0] ALL_ONES = '1;
   localparam int RANDOM_BEATS = 1560;
   localparam int N_DIRECTED   = 35;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lsf_req_if req_ch();
   lsf_rsp_if rsp_ch();
   lsf_csr_if csr_ch();

   line_substring_filter dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #5ns clock = ~clock;

   logic [7:0]        pat_bytes [MAX_PATTERN];
   logic [PLEN_W-1:0] pat_len_reg = '0;
   logic [7:0]        window [MAX_PATTERN];
   int                line_count = 0;
   bit                line_found = 1'b0;
   bit                line_nul = 1'b0;

   line_result_type pending_lines [$];
   int error_count = 0;
   int beats_taken = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int stall_cycles = 0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_END,  '0, '0, CHR_NUL, 1'b1, 1'b1, 9'd0},
      '{ROW_CHAR, '0, '0, 8'hff,   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_END,  '0, '0, CHR_NUL, 1'b1, 1'b1, 9'd2},
      '{ROW_REG,  REG_PATTERN_LENGTH, 64'd3, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_BYTES0, {40'd0, CHR_C, CHR_B, CHR_A}, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_X,   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_A,   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_B,   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_C,   1'b0, 1'b0, 9'd0},
      '{ROW_END,  '0, '0, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_A,   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_B,   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_C,   1'b0, 1'b0, 9'd0},
      '{ROW_END,  '0, '0, 8'hff,   1'b0, 1'b0, 9'd0},
      '{ROW_END,  '0, '0, CHR_NUL, 1'b1, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_LENGTH, 64'd63, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_BYTES0, {40'd0, CHR_B, CHR_NUL, CHR_A}, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_A,   1'b0, 1'b0, 9'd0},
      '{ROW_END,  '0, '0, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_LAST_INDEX,  ALL_ONES, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_BEYOND_LIST, ALL_ONES, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, CHR_Z,   1'b0, 1'b0, 9'd0},
      '{ROW_END,  '0, '0, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_BYTES0, ALL_ONES, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_BYTES1, ALL_ONES, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_BYTES2, ALL_ONES, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_BYTES3, ALL_ONES, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_LENGTH, 64'd32, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, 8'hff,   1'b0, 1'b0, 9'd0},
      '{ROW_END,  '0, '0, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_REG,  REG_PATTERN_LENGTH, 64'd0, CHR_NUL, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR, '0, '0, 8'h80,   1'b0, 1'b0, 9'd0},
      '{ROW_END,  '0, '0, CHR_NUL, 1'b1, 1'b1, 9'd1}
   };

   function automatic int pattern_span();
      int n;
      n = (int'(pat_len_reg) > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_reg);
      for (int i = 0; i < n; i++) begin
         if (pat_bytes[i] == CHR_NUL) return i;
      end
      return n;
   endfunction

   function automatic bit scan_beat(input logic [7:0] ch, input bit eol,
                                    output line_result_type res);
      int  span;
      bit  hit;
      res.matched = 1'b0;
      res.length  = '0;
      if (eol) begin
         res.matched = line_found || (pattern_span() == 0);
         res.length  = LENGTH_W'(line_count);
         line_count  = 0;
         line_found  = 1'b0;
         line_nul    = 1'b0;
         foreach (window[i]) window[i] = CHR_NUL;
         return 1'b1;
      end
      if (line_count >= LINE_LIMIT) return 1'b0;
      line_count++;
      if (ch == CHR_NUL) line_nul = 1'b1;
      if (line_nul) return 1'b0;
      for (int i = 0; i < MAX_PATTERN - 1; i++) window[i] = window[i+1];
      window[MAX_PATTERN-1] = ch;
      span = pattern_span();
      if (span > 0) begin
         hit = 1'b1;
         for (int i = 0; i < span; i++) begin
            if (window[MAX_PATTERN-span+i] != pat_bytes[i]) hit = 1'b0;
         end
         if (hit) line_found = 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_beat(input logic [7:0] ch, input bit eol, input bit typed,
                            input line_result_type typed_res);
      line_result_type res;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.text_byte <= ch;
      req_ch.line_end  <= eol;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      beats_taken++;
      if (scan_beat(ch, eol, res)) pending_lines.push_back(typed ? typed_res : res);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      req_ch.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      if (index == REG_PATTERN_LENGTH) begin
         pat_len_reg = data[PLEN_W-1:0];
      end else if (index >= REG_PATTERN_BYTES0 && index <= REG_PATTERN_BYTES3) begin
         for (int k = 0; k < WORD_BYTES; k++) begin
            pat_bytes[(int'(index) - int'(REG_PATTERN_BYTES0)) * WORD_BYTES + k] = data[8*k +: 8];
         end
      end
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_lines.size() == 0) begin
            report_mismatch("result beat with nothing expected, length", rsp_ch.line_length, 0);
         end else begin
            want = pending_lines.pop_front();
            if (rsp_ch.line_matched !== want.matched)
               report_mismatch("line_matched", rsp_ch.line_matched, want.matched);
            if (rsp_ch.line_length !== want.length)
               report_mismatch("line_length", rsp_ch.line_length, want.length);
         end
      end
   end

   initial begin
      line_result_type         typed_res;
      logic [7:0]              text_q [$];
      logic [CSR_DATA_W-1:0]   word;
      logic [PLEN_W-1:0]       plen;
      int                      mode_target;
      int                      lines;
      int                      line_len;
      int                      style;
      int                      span;
      int                      embed;
      int                      pos;
      int                      pick;
      bit                      long_line;
      bit                      first_setting;

      foreach (pat_bytes[i]) pat_bytes[i] = CHR_NUL;
      foreach (window[i]) window[i] = CHR_NUL;
      req_ch.valid     <= 1'b0;
      req_ch.text_byte <= '0;
      req_ch.line_end  <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= '0;
      csr_ch.data      <= '0;
      reset            <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         typed_res.matched = directed_rows[r].matched;
         typed_res.length  = directed_rows[r].length;
         case (directed_rows[r].kind)
            ROW_REG:  write_reg(directed_rows[r].index, directed_rows[r].data);
            ROW_CHAR: send_beat(directed_rows[r].ch, 1'b0, 1'b0, typed_res);
            default:  send_beat(directed_rows[r].ch, 1'b1, directed_rows[r].typed, typed_res);
         endcase
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               sender_idle_pct   = 17;
               receiver_idle_pct = 55;
            end
            1: begin
               sender_idle_pct   = 55;
               receiver_idle_pct = 17;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         mode_target   = beats_taken + RANDOM_BEATS / 3;
         first_setting = 1'b1;
         while (beats_taken < mode_target) begin
            pick = $urandom_range(99);
            if (pick < 10)      plen = 6'd0;
            else if (pick < 20) plen = 6'd63;
            else if (pick < 30) plen = 6'd32;
            else if (pick < 40) plen = PLEN_W'($urandom_range(33, 62));
            else                plen = PLEN_W'($urandom_range(1, 8));
            for (int w = 0; w < 4; w++) begin
               for (int k = 0; k < WORD_BYTES; k++) begin
                  pick = $urandom_range(99);
                  if (pick < 4)       word[8*k +: 8] = CHR_NUL;
                  else if (pick < 14) word[8*k +: 8] = 8'($urandom_range(1, 255));
                  else                word[8*k +: 8] = $urandom_range(1) ? CHR_A : CHR_B;
               end
               write_reg(CSR_INDEX_W'(int'(REG_PATTERN_BYTES0) + w), word);
            end
            word = {$urandom, $urandom};
            word[PLEN_W-1:0] = plen;
            write_reg(REG_PATTERN_LENGTH, word);
            if ($urandom_range(4) == 0)
               write_reg($urandom_range(1) ? REG_BEYOND_LIST : REG_LAST_INDEX,
                         {$urandom, $urandom});
            if (mode == 2 && first_setting) stall_cycles = 80;

            lines = $urandom_range(4, 10);
            for (int n = 0; n < lines; n++) begin
               long_line = first_setting && (n == 0);
               line_len  = long_line ? $urandom_range(LINE_LIMIT, LINE_LIMIT + 16)
                                     : $urandom_range(0, 16);
               style     = long_line ? $urandom_range(10, 69) : $urandom_range(99);
               text_q.delete();
               for (int i = 0; i < line_len; i++) begin
                  if (style < 10)
                     text_q.push_back(8'($urandom_range(0, 255)));
                  else if ($urandom_range(99) < 85)
                     text_q.push_back($urandom_range(1) ? CHR_A : CHR_B);
                  else
                     text_q.push_back(8'($urandom_range(1, 255)));
               end
               span = pattern_span();
               if (style >= 10 && style < 70 && span > 0) begin
                  embed = (style < 55) ? span : span - 1;
                  while (text_q.size() < embed) text_q.push_back(CHR_A);
                  if (long_line) begin
                     pos = $urandom_range(LINE_LIMIT - embed - 2, LINE_LIMIT - embed + 2);
                     if (pos > text_q.size() - embed) pos = text_q.size() - embed;
                  end else begin
                     pos = $urandom_range(0, text_q.size() - embed);
                  end
                  for (int i = 0; i < embed; i++) text_q[pos+i] = pat_bytes[i];
               end
               if (style >= 70 && style < 80 && text_q.size() > 0)
                  text_q[$urandom_range(0, text_q.size() - 1)] = CHR_NUL;
               foreach (text_q[i]) send_beat(text_q[i], 1'b0, 1'b0, typed_res);
               send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, typed_res);
            end
            first_setting = 1'b0;
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout: results still outstanding");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== line_substring_filter.f =====
rtl/core/lsf_pkg.sv
rtl/core/lsf_intf.sv
rtl/core/lsf_csr.sv
rtl/core/lsf_cell.sv
rtl/core/line_substring_filter.sv
rtl/core/lsf_checker.sv
sim/tb_top.sv
